/* hw/rtl/aprb_pkg.sv */
// Shared constants and types for the audio playout ring buffer.
`default_nettype none
package aprb_pkg;

	localparam int unsigned DEPTH_DEFAULT = 16384;
	localparam int unsigned LEVEL_W       = 15;
	localparam int unsigned FMT_W         = 3;
	localparam int unsigned FILL_W        = 15;
	localparam int unsigned SAMPLE_W      = 16;

	localparam logic [FMT_W-1:0] FMT_U8    = 3'd0;
	localparam logic [FMT_W-1:0] FMT_S8    = 3'd1;
	localparam logic [FMT_W-1:0] FMT_U16LE = 3'd2;
	localparam logic [FMT_W-1:0] FMT_U16BE = 3'd3;
	localparam logic [FMT_W-1:0] FMT_U16NE = 3'd4;
	localparam logic [FMT_W-1:0] FMT_S16LE = 3'd5;
	localparam logic [FMT_W-1:0] FMT_S16BE = 3'd6;
	localparam logic [FMT_W-1:0] FMT_S16NE = 3'd7;

	localparam logic [FMT_W-1:0]   FMT_RESET   = FMT_S16LE;
	localparam logic [LEVEL_W-1:0] LEVEL_RESET = 15'd4096;

	localparam logic [7:0]          FLIP8  = 8'h80;
	localparam logic [SAMPLE_W-1:0] FLIP16 = 16'h8000;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_PREBUF   = 2'd1,
		STAT_UNDERRUN = 2'd2,
		STAT_OVERFLOW = 2'd3
	} status_t;

	typedef enum logic {
		REG_FORMAT = 1'b0,
		REG_LEVEL  = 1'b1
	} reg_idx_t;

	typedef enum logic {
		KIND_PUSH = 1'b0,
		KIND_PULL = 1'b1
	} kind_t;

	typedef struct packed {
		logic [FILL_W-1:0]   fill;
		status_t             status;
		logic                valid;
		logic [SAMPLE_W-1:0] sample;
	} result_t;

endpackage
`default_nettype wire

/* hw/rtl/audio_playout_ring_buffer.sv */
// Audio playout ring buffer: byte store, pointers, prebuffer gate and sample conversion.
// A push, or a pull with no sample, forms its result on acceptance; a sample pull reads a byte
// in S_IDLE and forms an 8-bit sample in S_RD1, or a 16-bit one in S_RD2 after a second read.
// Throughput: one push per cycle while the skid entry is empty; a sample pull holds the input in
// S_RD1 and, for 16 bits, S_RD2, reading one byte a cycle through the store's single read port.
// Reset: pointers and count cleared, prebuffering set, format s16le, prebuffer level 4096.
// The byte store is not cleared; bytes are only read after they were written.
`default_nettype none
module audio_playout_ring_buffer #(
	parameter int unsigned BUFFER_DEPTH = aprb_pkg::DEPTH_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
	input  wire logic        s_tuser,   // [0] kind
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // [15:0] sample_out, [17:16] status, [32:18] fill_level
	output logic             m_tuser,   // [0] sample_valid
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [14:0] cfg_wdata
);

	localparam int unsigned PTR_W = $clog2(BUFFER_DEPTH);
	localparam int unsigned CNT_W = $clog2(BUFFER_DEPTH + 1);
	localparam int unsigned CMP_W = (CNT_W > aprb_pkg::LEVEL_W) ? CNT_W : aprb_pkg::LEVEL_W;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(BUFFER_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(BUFFER_DEPTH);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RD1  = 3'b010,
		S_RD2  = 3'b100
	} state_t;

	// Byte store
	logic [7:0] mem [BUFFER_DEPTH];
	logic [7:0] rd_data;
	logic [PTR_W-1:0] rd_addr;
	logic mem_we;

	state_t state_q;
	logic [PTR_W-1:0] wp_q, rp_q, rp1_s1;
	logic [CNT_W-1:0] cnt_q;
	logic prebuf_q;
	logic [aprb_pkg::FMT_W-1:0] fmt_q;
	logic [aprb_pkg::LEVEL_W-1:0] level_q;

	logic wide_s1, swap_s1, flip_s1;
	logic [7:0] lo_s2;
	logic [aprb_pkg::FILL_W-1:0] fill_s1;

	aprb_pkg::result_t out_q, skid_q;
	logic out_v_q, skid_v_q;

	// Item decode
	logic accept, is_pull, full, wide, pb_next, enough, pull_ok;
	logic [PTR_W-1:0] rp1, rp2, wp1;
	logic [CNT_W-1:0] cnt_nxt;
	logic [CMP_W-1:0] cnt_ext, lvl_ext, nxt_ext;
	aprb_pkg::status_t stat_now;

	aprb_pkg::result_t new_res;
	logic produce;
	aprb_pkg::result_t deferred;
	logic [aprb_pkg::SAMPLE_W-1:0] raw16;

	assign s_tready = (state_q == S_IDLE) && !skid_v_q;
	assign accept   = s_tvalid && s_tready;
	assign is_pull  = (s_tuser == aprb_pkg::KIND_PULL);
	assign full     = (cnt_q == CNT_FULL);
	assign wide     = (fmt_q >= aprb_pkg::FMT_U16LE);

	assign rp1 = (rp_q == PTR_LAST) ? '0 : rp_q + PTR_W'(1);
	assign rp2 = (rp1 == PTR_LAST) ? '0 : rp1 + PTR_W'(1);
	assign wp1 = (wp_q == PTR_LAST) ? '0 : wp_q + PTR_W'(1);

	assign cnt_ext = CMP_W'(cnt_q);
	assign lvl_ext = CMP_W'(level_q);
	assign pb_next = prebuf_q && !(cnt_ext > lvl_ext);
	assign enough  = wide ? (cnt_q >= CNT_W'(2)) : (cnt_q >= CNT_W'(1));
	assign pull_ok = !pb_next && enough;
	assign mem_we  = accept && !is_pull && !full;

	always_comb begin
		cnt_nxt  = cnt_q;
		stat_now = aprb_pkg::STAT_OK;
		if (!is_pull) begin
			if (full) stat_now = aprb_pkg::STAT_OVERFLOW;
			else cnt_nxt = cnt_q + CNT_W'(1);
		end else if (pb_next) begin
			stat_now = aprb_pkg::STAT_PREBUF;
		end else if (!enough) begin
			stat_now = aprb_pkg::STAT_UNDERRUN;
		end else begin
			cnt_nxt = cnt_q - (wide ? CNT_W'(2) : CNT_W'(1));
		end
	end
	assign nxt_ext = CMP_W'(cnt_nxt);

	assign rd_addr = (state_q == S_IDLE) ? rp_q : rp1_s1;

	always_ff @(posedge clk) begin
		if (mem_we) mem[wp_q] <= s_tdata;
		rd_data <= mem[rd_addr];
	end

	// Sample conversion; first byte is the low byte before any swap
	assign raw16 = swap_s1 ? {lo_s2, rd_data} : {rd_data, lo_s2};
	always_comb begin
		deferred        = '0;
		deferred.valid  = 1'b1;
		deferred.status = aprb_pkg::STAT_OK;
		deferred.fill   = fill_s1;
		if (wide_s1) deferred.sample = raw16 ^ (flip_s1 ? aprb_pkg::FLIP16 : '0);
		else deferred.sample = {8'h00, rd_data ^ (flip_s1 ? aprb_pkg::FLIP8 : 8'h00)};
	end

	always_comb begin
		produce = 1'b0;
		new_res = deferred;
		priority case (1'b1)
			(state_q == S_RD1 && !wide_s1): produce = 1'b1;
			(state_q == S_RD2): produce = 1'b1;
			(accept && !(is_pull && pull_ok)): begin
				produce        = 1'b1;
				new_res.sample = '0;
				new_res.valid  = 1'b0;
				new_res.status = stat_now;
				new_res.fill   = nxt_ext[aprb_pkg::FILL_W-1:0];
			end
			default: produce = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			wp_q     <= '0;
			rp_q     <= '0;
			cnt_q    <= '0;
			prebuf_q <= 1'b1;
			fmt_q    <= aprb_pkg::FMT_RESET;
			level_q  <= aprb_pkg::LEVEL_RESET;
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (aprb_pkg::reg_idx_t'(cfg_index))
					aprb_pkg::REG_FORMAT: fmt_q <= cfg_wdata[aprb_pkg::FMT_W-1:0];
					aprb_pkg::REG_LEVEL:  level_q <= cfg_wdata;
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cnt_q <= cnt_nxt;
						if (!is_pull) begin
							if (!full) wp_q <= wp1;
						end else begin
							prebuf_q <= pb_next;
							if (pull_ok) begin
								rp_q    <= wide ? rp2 : rp1;
								state_q <= S_RD1;
							end
						end
					end
				end
				S_RD1: state_q <= wide_s1 ? S_RD2 : S_IDLE;
				S_RD2: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
			// Output register with one skid entry
			if (produce) begin
				if (!out_v_q || m_tready) begin
					out_v_q  <= 1'b1;
					skid_v_q <= 1'b0;
				end else begin
					skid_v_q <= 1'b1;
				end
			end else if (m_tready) begin
				out_v_q  <= skid_v_q;
				skid_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rp1_s1  <= rp1;
			fill_s1 <= nxt_ext[aprb_pkg::FILL_W-1:0];
			wide_s1 <= wide;
			swap_s1 <= (fmt_q == aprb_pkg::FMT_U16BE) || (fmt_q == aprb_pkg::FMT_S16BE);
			flip_s1 <= (fmt_q == aprb_pkg::FMT_S8) || (fmt_q == aprb_pkg::FMT_U16LE)
				|| (fmt_q == aprb_pkg::FMT_U16BE) || (fmt_q == aprb_pkg::FMT_U16NE);
		end
		if (state_q == S_RD1) lo_s2 <= rd_data;
		if (produce) begin
			if (!out_v_q || m_tready) begin
				out_q <= skid_v_q ? skid_q : new_res;
				if (skid_v_q) skid_q <= new_res;
			end else begin
				skid_q <= new_res;
			end
		end else if (m_tready && skid_v_q) begin
			out_q <= skid_q;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = out_q.valid;
	assign m_tdata  = {7'b0, out_q.fill, out_q.status, out_q.sample};

	// Fill count stays within the store
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_FULL)
		else $error("byte count beyond depth");

	// Skid entry only holds while the output register is occupied
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry without output entry");

	// Input is only taken while no memory read is in flight
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (state_q == S_IDLE))
		else $error("ready during sample read");

	// A delivered sample always carries ok status
	a_sample_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[17:16] == aprb_pkg::STAT_OK))
		else $error("sample with error status");

	// A 16-bit sample read ends after S_RD2: that state is always followed by S_IDLE
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD2) |=> (state_q == S_IDLE))
		else $error("read sequence overran");

endmodule
`default_nettype wire

/* tb/tb_audio_playout_ring_buffer.sv */
// Self-checking testbench for the audio playout ring buffer.
`timescale 1ns / 1ps
module tb_audio_playout_ring_buffer;
	import aprb_pkg::*;

	localparam int unsigned DEPTH = DEPTH_DEFAULT;
	localparam int unsigned STALL_LIMIT = 1000;

	typedef enum {OP_ITEM, OP_CFG, OP_FILL, OP_DRAIN} plan_op_t;

	typedef struct {
		plan_op_t          op;
		kind_t             kind;
		logic [7:0]        data;
		reg_idx_t          reg_sel;
		logic [LEVEL_W-1:0] value;
		logic              has_want;
		result_t           want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic s_tuser = KIND_PUSH;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic m_tuser;
	logic cfg_we = 1'b0;
	logic cfg_index = REG_FORMAT;
	logic [LEVEL_W-1:0] cfg_wdata = '0;

	// playout model state
	logic [7:0]         ring [DEPTH];
	int unsigned        wr_idx = 0;
	int unsigned        rd_idx = 0;
	int unsigned        fill_cnt = 0;
	logic               prebuf = 1'b1;
	logic [FMT_W-1:0]   cur_fmt = FMT_RESET;
	logic [LEVEL_W-1:0] cur_level = LEVEL_RESET;

	result_t     pending_results[$];
	plan_row_t   plan[$];
	logic        no_gaps = 1'b0;
	int unsigned mismatches = 0;
	int unsigned results_seen = 0;
	int unsigned n_items = 0;
	int unsigned n_samples = 0;
	int unsigned n_underrun = 0;
	int unsigned n_prebuf = 0;
	int unsigned n_overflow = 0;
	int unsigned quiet_cycles = 0;

	audio_playout_ring_buffer #(
		.BUFFER_DEPTH(DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [7:0] pop_byte();
		logic [7:0] b;
		b = ring[rd_idx];
		rd_idx = (rd_idx + 1 == DEPTH) ? 0 : rd_idx + 1;
		fill_cnt--;
		return b;
	endfunction

	function automatic result_t play_step(kind_t kind, logic [7:0] din);
		result_t r;
		logic wide;
		logic [SAMPLE_W-1:0] smp;
		r = '0;
		r.status = STAT_OK;
		if (kind == KIND_PUSH) begin
			if (fill_cnt >= DEPTH) begin
				r.status = STAT_OVERFLOW;
			end else begin
				ring[wr_idx] = din;
				wr_idx = (wr_idx + 1 == DEPTH) ? 0 : wr_idx + 1;
				fill_cnt++;
			end
		end else begin
			wide = (cur_fmt >= FMT_U16LE);
			// prebuffer gate opens once and stays open
			if (prebuf && fill_cnt > cur_level)
				prebuf = 1'b0;
			if (prebuf) begin
				r.status = STAT_PREBUF;
			end else if (fill_cnt < (wide ? 2 : 1)) begin
				r.status = STAT_UNDERRUN;
			end else begin
				if (wide) begin
					smp[7:0] = pop_byte();
					smp[15:8] = pop_byte();
					if (cur_fmt == FMT_U16BE || cur_fmt == FMT_S16BE)
						smp = {smp[7:0], smp[15:8]};
					if (cur_fmt >= FMT_U16LE && cur_fmt <= FMT_U16NE)
						smp ^= FLIP16;
				end else begin
					smp = {8'h00, pop_byte()};
					if (cur_fmt == FMT_S8)
						smp[7:0] ^= FLIP8;
				end
				r.sample = smp;
				r.valid = 1'b1;
			end
		end
		r.fill = FILL_W'(fill_cnt);
		case (r.status)
			STAT_OK:       if (r.valid) n_samples++;
			STAT_PREBUF:   n_prebuf++;
			STAT_UNDERRUN: n_underrun++;
			STAT_OVERFLOW: n_overflow++;
		endcase
		return r;
	endfunction

	function automatic plan_row_t row_item(kind_t k, logic [7:0] d);
		plan_row_t r;
		r.op = OP_ITEM;
		r.kind = k;
		r.data = d;
		r.reg_sel = REG_FORMAT;
		r.value = '0;
		r.has_want = 1'b0;
		r.want = '0;
		return r;
	endfunction

	function automatic plan_row_t row_checked(kind_t k, logic [7:0] d, status_t st,
			logic [SAMPLE_W-1:0] smp, logic vld, logic [FILL_W-1:0] fl);
		plan_row_t r;
		r = row_item(k, d);
		r.has_want = 1'b1;
		r.want.sample = smp;
		r.want.valid = vld;
		r.want.status = st;
		r.want.fill = fl;
		return r;
	endfunction

	function automatic plan_row_t row_cfg(reg_idx_t sel, logic [LEVEL_W-1:0] v);
		plan_row_t r;
		r = row_item(KIND_PUSH, 8'h00);
		r.op = OP_CFG;
		r.reg_sel = sel;
		r.value = v;
		return r;
	endfunction

	function automatic plan_row_t row_bulk(plan_op_t o);
		plan_row_t r;
		r = row_item(KIND_PUSH, 8'h00);
		r.op = o;
		return r;
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_item(kind_t k, logic [7:0] d, logic has_want, result_t want);
		result_t r;
		while (!no_gaps && $urandom_range(99) < 26) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= k;
		s_tdata <= d;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		r = play_step(k, d);
		pending_results.push_back(has_want ? want : r);
		n_items++;
		@(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t sel, logic [LEVEL_W-1:0] v);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (sel == REG_FORMAT)
			cur_fmt = v[FMT_W-1:0];
		else
			cur_level = v;
	endtask

	always @(negedge clk)
		m_tready <= no_gaps || ($urandom_range(99) >= 26);

	always @(posedge clk) begin
		result_t want;
		logic bad;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: result %0d arrived with nothing pending (tdata %h)",
						results_seen, m_tdata);
			end else begin
				want = pending_results.pop_front();
				bad = (m_tdata[15:0] !== want.sample) || (m_tuser !== want.valid) ||
					(m_tdata[17:16] !== want.status) || (m_tdata[32:18] !== want.fill) ||
					(m_tdata[39:33] !== '0);
				if (bad) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"ERROR: result %0d exp sample %h valid %b status %0d fill %0d",
							" / got sample %h valid %b status %0d fill %0d pad %h"},
							results_seen, want.sample, want.valid, want.status, want.fill,
							m_tdata[15:0], m_tuser, m_tdata[17:16], m_tdata[32:18],
							m_tdata[39:33]);
				end
			end
		end
	end

	// watchdog: cycles with no transaction on either side
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("ERROR: no transaction for %0d cycles, %0d results pending",
				quiet_cycles, pending_results.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		int unsigned push_pct;
		kind_t k;
		logic [FMT_W-1:0] fmt;
		logic [LEVEL_W-1:0] lvl;

		// still prebuffering: gate closed until the level is exceeded
		plan.push_back(row_checked(KIND_PULL, 8'hFF, STAT_PREBUF, 16'h0000, 1'b0, 15'd0));
		plan.push_back(row_checked(KIND_PUSH, 8'h00, STAT_OK, 16'h0000, 1'b0, 15'd1));
		plan.push_back(row_cfg(REG_LEVEL, 15'd1));
		plan.push_back(row_checked(KIND_PULL, 8'h00, STAT_PREBUF, 16'h0000, 1'b0, 15'd1));
		// level at depth: full buffer never opens the gate
		plan.push_back(row_cfg(REG_LEVEL, 15'd16384));
		plan.push_back(row_bulk(OP_FILL));
		plan.push_back(row_checked(KIND_PUSH, 8'hFF, STAT_OVERFLOW, 16'h0000, 1'b0, 15'd16384));
		plan.push_back(row_checked(KIND_PULL, 8'h00, STAT_PREBUF, 16'h0000, 1'b0, 15'd16384));
		plan.push_back(row_cfg(REG_LEVEL, 15'd16383));
		plan.push_back(row_bulk(OP_DRAIN));
		plan.push_back(row_checked(KIND_PULL, 8'h00, STAT_UNDERRUN, 16'h0000, 1'b0, 15'd0));
		plan.push_back(row_cfg(REG_FORMAT, FMT_U8));
		plan.push_back(row_item(KIND_PUSH, 8'h00));
		plan.push_back(row_checked(KIND_PULL, 8'h00, STAT_OK, 16'h0000, 1'b1, 15'd0));
		plan.push_back(row_checked(KIND_PULL, 8'h00, STAT_UNDERRUN, 16'h0000, 1'b0, 15'd0));
		plan.push_back(row_cfg(REG_FORMAT, FMT_S8));
		plan.push_back(row_item(KIND_PUSH, 8'h00));
		plan.push_back(row_item(KIND_PUSH, 8'hFF));
		plan.push_back(row_item(KIND_PULL, 8'h00));
		plan.push_back(row_item(KIND_PULL, 8'h00));
		plan.push_back(row_cfg(REG_FORMAT, FMT_U16LE));
		plan.push_back(row_item(KIND_PUSH, 8'h34));
		plan.push_back(row_item(KIND_PUSH, 8'h12));
		plan.push_back(row_item(KIND_PULL, 8'h00));
		// one byte held, a 16-bit pull must underrun
		plan.push_back(row_item(KIND_PUSH, 8'hAB));
		plan.push_back(row_item(KIND_PULL, 8'h00));
		plan.push_back(row_cfg(REG_FORMAT, FMT_U16BE));
		plan.push_back(row_item(KIND_PUSH, 8'hCD));
		plan.push_back(row_item(KIND_PULL, 8'h00));
		plan.push_back(row_cfg(REG_FORMAT, FMT_U16NE));
		plan.push_back(row_item(KIND_PUSH, 8'hFF));
		plan.push_back(row_item(KIND_PUSH, 8'hFF));
		plan.push_back(row_item(KIND_PULL, 8'h00));
		plan.push_back(row_cfg(REG_FORMAT, FMT_S16NE));
		plan.push_back(row_item(KIND_PUSH, 8'h00));
		plan.push_back(row_item(KIND_PUSH, 8'h80));
		plan.push_back(row_item(KIND_PULL, 8'h00));
		plan.push_back(row_cfg(REG_FORMAT, FMT_S16BE));
		plan.push_back(row_item(KIND_PUSH, 8'h01));
		plan.push_back(row_item(KIND_PUSH, 8'h02));
		plan.push_back(row_item(KIND_PULL, 8'h00));

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			case (plan[i].op)
				OP_ITEM: begin
					send_item(plan[i].kind, plan[i].data, plan[i].has_want, plan[i].want);
				end
				OP_CFG: begin
					write_reg(plan[i].reg_sel, plan[i].value);
				end
				OP_FILL: begin
					while (fill_cnt < DEPTH)
						send_item(KIND_PUSH, 8'($urandom_range(255)), 1'b0, '0);
				end
				OP_DRAIN: begin
					while (fill_cnt >= 2)
						send_item(KIND_PULL, 8'($urandom_range(255)), 1'b0, '0);
				end
			endcase
		end

		for (int ph = 0; ph < 6; ph++) begin
			fmt = (ph == 0) ? FMT_U8 : (ph == 1) ? FMT_S16NE : FMT_W'($urandom_range(7));
			lvl = (ph == 0) ? '0 : (ph == 1) ? 15'd16384 : LEVEL_W'($urandom_range(16384));
			write_reg(REG_FORMAT, fmt);
			write_reg(REG_LEVEL, lvl);
			no_gaps = (ph == 2);
			repeat (100) begin
				// lean toward pushes when nearly empty so most pulls return samples
				push_pct = (fill_cnt < 4) ? 80 : (fill_cnt > 64) ? 30 : 55;
				k = ($urandom_range(99) < push_pct) ? KIND_PUSH : KIND_PULL;
				send_item(k, 8'($urandom_range(255)), 1'b0, '0);
			end
		end
		no_gaps = 1'b0;

		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);

		$display("Sent %0d transactions: %0d samples played, %0d underruns, %0d prebuffer holds,",
			n_items, n_samples, n_underrun, n_prebuf);
		$display("%0d overflow drops; all formats and prebuffer levels 0..16384; %0d mismatches.",
			n_overflow, mismatches);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

/* files.f */
hw/rtl/aprb_pkg.sv
hw/rtl/audio_playout_ring_buffer.sv
tb/tb_audio_playout_ring_buffer.sv
